@@ rtl/tcce_pkg.sv @@
// Package for the text console cursor engine: command, request-kind and
// sequencer state types, register indexes, character codes and defaults.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tcce_pkg;

   // Default screen geometry and queue depth.
   localparam int SCREEN_WIDTH_DEF  = 80;
   localparam int SCREEN_HEIGHT_DEF = 25;
   localparam int QUEUE_DEPTH_DEF   = 2;

   // Fixed field widths.
   localparam int COLOR_W     = 4;
   localparam int TAB_W       = 7;
   localparam int CHAR_W      = 8;
   localparam int ROW_OUT_W   = 5;
   localparam int COL_OUT_W   = 7;
   localparam int CELL_W      = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;

   // Register reset values.
   localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd15;
   localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;
   localparam logic [TAB_W-1:0]   TAB_SIZE_RESET   = 7'd8;

   // Character codes.
   localparam logic [CHAR_W-1:0] CHAR_TAB         = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE     = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN      = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_FIRST_PRINT = 8'h20;

   // Input operation codes.
   localparam logic OP_CHARACTER = 1'b0;
   localparam logic OP_CLEAR     = 1'b1;

   typedef enum logic [1:0] {
      REG_FOREGROUND = 2'd0,
      REG_BACKGROUND = 2'd1,
      REG_TAB_SIZE   = 2'd2
   } reg_type;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_SCROLL = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_CLEAR,
      KIND_PRINT,
      KIND_NEWLINE,
      KIND_RETURN,
      KIND_TAB
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_TAB,
      BK_WRITE
   } back_state_type;

   // One classified request as it sits in the queue.
   typedef struct packed {
      kind_type           kind;
      logic [CHAR_W-1:0]  char_code;
      logic [TAB_W-1:0]   tab_size;
   } entry_type;

   // Front to queue.
   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   // Queue occupancy seen by both sides.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

@@ rtl/tcce_csr.sv @@
// Configuration registers of the text console cursor engine behind an
// APB-style port: colours and tab size. Depends on tcce_pkg.
`default_nettype none

module tcce_csr
   import tcce_pkg::*;
#(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [COLOR_W-1:0]    foreground,
   output logic      [COLOR_W-1:0]    background,
   output logic      [TAB_W-1:0]      tab_size
);

   logic [COLOR_W-1:0] fg_ff, fg_in;
   logic [COLOR_W-1:0] bg_ff, bg_in;
   logic [TAB_W-1:0]   tab_ff, tab_in;
   logic               wr_en;
   reg_type            reg_sel;
   logic [TAB_W-1:0]   tab_wdata;
   logic               tab_ok;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_sel   = reg_type'(paddr[3:2]);
   assign tab_wdata = pwdata[TAB_W-1:0];
   // A tab size of zero or of a full line or more is refused.
   assign tab_ok    = (tab_wdata != '0) && (32'(tab_wdata) < 32'(SCREEN_WIDTH));

   always_comb begin
      fg_in  = fg_ff;
      bg_in  = bg_ff;
      tab_in = tab_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_FOREGROUND: fg_in = pwdata[COLOR_W-1:0];
            REG_BACKGROUND: bg_in = pwdata[COLOR_W-1:0];
            REG_TAB_SIZE: begin
               if (tab_ok) begin
                  tab_in = tab_wdata;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff  <= FOREGROUND_RESET;
         bg_ff  <= BACKGROUND_RESET;
         tab_ff <= TAB_SIZE_RESET;
      end else begin
         fg_ff  <= fg_in;
         bg_ff  <= bg_in;
         tab_ff <= tab_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_FOREGROUND: prdata = CSR_DATA_W'(fg_ff);
         REG_BACKGROUND: prdata = CSR_DATA_W'(bg_ff);
         REG_TAB_SIZE:   prdata = CSR_DATA_W'(tab_ff);
         default:        prdata = '0;
      endcase
   end

   assign foreground = fg_ff;
   assign background = bg_ff;
   assign tab_size   = tab_ff;

endmodule

`default_nettype wire

@@ rtl/tcce_front.sv @@
// Front end of the text console cursor engine: accepts requests, sorts them
// into kinds, drops ignored codes and pushes the rest. Depends on tcce_pkg.
`default_nettype none

module tcce_front
   import tcce_pkg::*;
(
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_operation,
   input  wire logic [CHAR_W-1:0] req_char_code,
   input  wire logic [TAB_W-1:0]  tab_size,
   input  wire queue_status_type  q_status,
   output push_type               q_push
);

   kind_type kind;
   logic     keep;

   always_comb begin
      kind = KIND_PRINT;
      keep = 1'b1;
      priority if (req_operation == OP_CLEAR) begin
         kind = KIND_CLEAR;
      end else if (req_char_code >= CHAR_FIRST_PRINT) begin
         kind = KIND_PRINT;
      end else if (req_char_code == CHAR_NEWLINE) begin
         kind = KIND_NEWLINE;
      end else if (req_char_code == CHAR_RETURN) begin
         kind = KIND_RETURN;
      end else if (req_char_code == CHAR_TAB) begin
         kind = KIND_TAB;
      end else begin
         keep = 1'b0;
      end
   end

   assign req_stall = q_status.full;

   // The tab size travels with the request so a later register write
   // cannot reach a tab still waiting in the queue.
   assign q_push.push            = req_valid && !q_status.full && keep;
   assign q_push.entry.kind      = kind;
   assign q_push.entry.char_code = req_char_code;
   assign q_push.entry.tab_size  = tab_size;

endmodule

`default_nettype wire

@@ rtl/tcce_queue.sv @@
// Short request queue between the front end and the back end of the text
// console cursor engine. Depends on tcce_pkg.
`default_nettype none

module tcce_queue
   import tcce_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire push_type    q_push,
   input  wire logic        pop,
   output entry_type        head,
   output queue_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign do_push = q_push.push && (count_ff != CNT_FULL);
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

   assign head           = slot_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CNT_FULL);

endmodule

`default_nettype wire

@@ rtl/tcce_back.sv @@
// Back end of the text console cursor engine: holds the cursor, carries out
// queued requests and drives the registered result channel. Depends on tcce_pkg.
`default_nettype none

module tcce_back
   import tcce_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire entry_type            head,
   input  wire queue_status_type     q_status,
   output logic                      pop,
   input  wire logic [COLOR_W-1:0]   foreground,
   input  wire logic [COLOR_W-1:0]   background,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_command,
   output logic [ROW_OUT_W-1:0]      rsp_screen_row,
   output logic [COL_OUT_W-1:0]      rsp_screen_column,
   output logic [CELL_W-1:0]         rsp_cell_word,
   output logic                      rsp_last
);

   // The column may sit one past the last cell while a wrap is pending.
   localparam int COL_W = $clog2(SCREEN_WIDTH + 1);
   localparam int ROW_W = $clog2(SCREEN_HEIGHT);
   localparam int CNT_W = $clog2(COL_W + 1);
   localparam logic [COL_W-1:0] COL_END  = COL_W'(SCREEN_WIDTH);
   localparam logic [COL_W:0]   SUM_END  = (COL_W + 1)'(SCREEN_WIDTH);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_HEIGHT - 1);

   back_state_type   state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [COL_W-1:0] tab_ff, tab_in;
   logic [COL_W:0]   rem_ff, rem_in;
   logic [COL_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic                 rsp_valid_ff;
   cmd_type              rsp_cmd_ff;
   logic [ROW_OUT_W-1:0] rsp_row_ff;
   logic [COL_OUT_W-1:0] rsp_col_ff;
   logic [CELL_W-1:0]    rsp_cell_ff;
   logic                 rsp_last_ff;

   logic                 out_free;
   logic                 at_bottom;
   logic                 col_full;
   logic                 start;
   logic [COL_W:0]       rem_shift;
   logic [COL_W:0]       rem_next;
   logic [COL_W:0]       tab_sum;
   logic [COL_W:0]       tab_wrapped;
   logic                 tab_wrap;

   logic                 emit;
   cmd_type              emit_cmd;
   logic [ROW_W-1:0]     emit_row;
   logic [COL_W-1:0]     emit_col;
   logic [CHAR_W-1:0]    emit_char;
   logic                 emit_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign at_bottom = (row_ff == ROW_LAST);
   assign col_full  = (col_ff >= COL_END);
   assign start     = (state_ff == BK_IDLE) && !q_status.empty && out_free;

   // One step of the restoring remainder unit.
   assign rem_shift = {rem_ff[COL_W-1:0], quo_ff[COL_W-1]};
   assign rem_next  = (rem_shift >= {1'b0, tab_ff}) ? rem_shift - {1'b0, tab_ff}
                                                    : rem_shift;

   // Next tab stop; it stays below two line widths, so one subtraction wraps it.
   assign tab_sum     = {1'b0, col_ff} + {1'b0, tab_ff} - rem_ff;
   assign tab_wrap    = (tab_sum >= SUM_END);
   assign tab_wrapped = tab_sum - SUM_END;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (start) begin
               if (head.kind == KIND_TAB) begin
                  state_in = BK_DIVIDE;
               end else if ((head.kind == KIND_PRINT) && col_full && at_bottom) begin
                  state_in = BK_WRITE;
               end
            end
         end
         BK_DIVIDE: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = BK_TAB;
            end
         end
         BK_TAB: begin
            if (!(tab_wrap && at_bottom) || out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_WRITE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      emit_cmd  = CMD_WRITE;
      emit_row  = row_ff;
      emit_col  = col_ff;
      emit_char = char_ff;
      emit_last = 1'b1;
      row_in    = row_ff;
      col_in    = col_ff;
      char_in   = char_ff;
      tab_in    = tab_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (start) begin
               pop     = 1'b1;
               char_in = head.char_code;
               tab_in  = COL_W'(head.tab_size);
               unique case (head.kind)
                  KIND_CLEAR: begin
                     emit     = 1'b1;
                     emit_cmd = CMD_CLEAR;
                     row_in   = '0;
                     col_in   = '0;
                  end
                  KIND_PRINT: begin
                     emit      = 1'b1;
                     emit_char = head.char_code;
                     if (!col_full) begin
                        col_in = col_ff + COL_W'(1);
                     end else if (!at_bottom) begin
                        emit_row = row_ff + ROW_W'(1);
                        emit_col = '0;
                        row_in   = row_ff + ROW_W'(1);
                        col_in   = COL_W'(1);
                     end else begin
                        // Scroll now, write the cell on the next free slot.
                        emit_cmd  = CMD_SCROLL;
                        emit_last = 1'b0;
                        col_in    = '0;
                     end
                  end
                  KIND_NEWLINE: begin
                     col_in = '0;
                     if (at_bottom) begin
                        emit     = 1'b1;
                        emit_cmd = CMD_SCROLL;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                     end
                  end
                  KIND_RETURN: begin
                     col_in = '0;
                  end
                  KIND_TAB: begin
                     rem_in = '0;
                     quo_in = col_ff;
                     cnt_in = CNT_W'(COL_W);
                  end
                  default: ;
               endcase
            end
         end
         BK_DIVIDE: begin
            rem_in = rem_next;
            quo_in = {quo_ff[COL_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         BK_TAB: begin
            if (!tab_wrap) begin
               col_in = tab_sum[COL_W-1:0];
            end else if (!at_bottom) begin
               col_in = tab_wrapped[COL_W-1:0];
               row_in = row_ff + ROW_W'(1);
            end else if (out_free) begin
               col_in   = tab_wrapped[COL_W-1:0];
               emit     = 1'b1;
               emit_cmd = CMD_SCROLL;
            end
         end
         BK_WRITE: begin
            if (out_free) begin
               emit   = 1'b1;
               col_in = col_ff + COL_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= emit || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      tab_ff  <= tab_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      if (emit) begin
         rsp_cmd_ff  <= emit_cmd;
         rsp_last_ff <= emit_last;
         if (emit_cmd == CMD_WRITE) begin
            rsp_row_ff  <= ROW_OUT_W'(emit_row);
            rsp_col_ff  <= COL_OUT_W'(emit_col);
            rsp_cell_ff <= {background, foreground, emit_char};
         end else begin
            rsp_row_ff  <= '0;
            rsp_col_ff  <= '0;
            rsp_cell_ff <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command       = rsp_cmd_ff;
   assign rsp_screen_row    = rsp_row_ff;
   assign rsp_screen_column = rsp_col_ff;
   assign rsp_cell_word     = rsp_cell_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/text_console_cursor_engine.sv @@
// Top level of the text console cursor engine: configuration registers,
// front end, request queue and back end. Depends on tcce_pkg and its modules.
//
// The engine takes character codes or a clear request and keeps a cursor on a
// SCREEN_WIDTH by SCREEN_HEIGHT text screen, emitting display commands: write
// one cell, scroll up one row with the bottom row blanked, or clear the screen.
// A clear request gives one clear command; a printable code gives a cell write,
// preceded by a scroll when a pending wrap falls on the bottom row; a newline
// on the bottom row and a tab that wraps on the bottom row give a scroll. The
// last result of each request carries rsp_last. Carriage return, newline and
// tab away from the bottom row change only the cursor; other control codes are
// dropped at the front and never reach the back end. The back end handles a
// clear, a printable code, a newline or a carriage return straight from idle;
// a write that needs a scroll first emits the scroll, then the cell write
// from its write state; a tab runs through the divide and tab states,
// because the distance to the next tab stop comes from a bit-serial remainder
// unit that settles one quotient bit per cycle. A queue of QUEUE_DEPTH
// requests sits between the front and the back, so the input keeps accepting
// while a result waits on a stalled output, until the queue is full. The tab
// size in force is captured with each request on acceptance.
`default_nettype none

module text_console_cursor_engine
   import tcce_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_operation,
   input  wire logic [CHAR_W-1:0]     req_char_code,
   // Result channel.
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_command,
   output logic [ROW_OUT_W-1:0]       rsp_screen_row,
   output logic [COL_OUT_W-1:0]       rsp_screen_column,
   output logic [CELL_W-1:0]          rsp_cell_word,
   output logic                       rsp_last,
   // Configuration port.
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic [COLOR_W-1:0] foreground;
   logic [COLOR_W-1:0] background;
   logic [TAB_W-1:0]   tab_size;
   push_type           q_push;
   queue_status_type   q_status;
   entry_type          head;
   logic               pop;

   // Colour and tab size registers.
   tcce_csr #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .foreground (foreground),
      .background (background),
      .tab_size   (tab_size)
   );

   // The front end sorts each request and stalls only when the queue is full.
   tcce_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_char_code (req_char_code),
      .tab_size      (tab_size),
      .q_status      (q_status),
      .q_push        (q_push)
   );

   tcce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   // The back end owns the cursor and takes a request only when its output
   // register can accept whatever the request may emit first.
   tcce_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_status          (q_status),
      .pop               (pop),
      .foreground        (foreground),
      .background        (background),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command       (rsp_command),
      .rsp_screen_row    (rsp_screen_row),
      .rsp_screen_column (rsp_screen_column),
      .rsp_cell_word     (rsp_cell_word),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for text_console_cursor_engine: register access, directed
// cursor cases and a long random run checked against a cursor predictor.
// Depends on tcce_pkg and the RTL of the block.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcce_pkg::*;

   localparam int COLUMNS = SCREEN_WIDTH_DEF;
   localparam int ROWS    = SCREEN_HEIGHT_DEF;

   // Cycles allowed after the last expected result for queued tabs, returns and
   // newlines to finish in the back end.
   localparam int SETTLE_CYCLES = 40;

   // Register index that lies beyond the register list.
   localparam int REG_UNLISTED = 3;

   // Control codes that the block must ignore, and the last character code.
   localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_ESCAPE    = 8'h1B;
   localparam logic [CHAR_W-1:0] CHAR_UNIT_SEP  = 8'h1F;
   localparam logic [CHAR_W-1:0] CHAR_LAST_CODE = 8'hFF;

   // One display command as the block should emit it.
   typedef struct {
      cmd_type                command;
      logic [ROW_OUT_W-1:0]   row;
      logic [COL_OUT_W-1:0]   column;
      logic [CELL_W-1:0]      cell_word;
      logic                   is_last;
   } display_cmd_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_operation;
   logic [CHAR_W-1:0]      req_char_code;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [1:0]             rsp_command;
   logic [ROW_OUT_W-1:0]   rsp_screen_row;
   logic [COL_OUT_W-1:0]   rsp_screen_column;
   logic [CELL_W-1:0]      rsp_cell_word;
   logic                   rsp_last;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [CSR_ADDR_W-1:0]  paddr;
   logic [CSR_DATA_W-1:0]  pwdata;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   // Predictor copy of the configuration and the cursor. The column is kept as
   // a plain integer because a tab from the pending-wrap column can briefly
   // carry it well past the line width before it is folded back.
   logic [COLOR_W-1:0]     text_fg;
   logic [COLOR_W-1:0]     text_bg;
   int                     tab_stop;
   int                     cursor_row;
   int                     cursor_column;

   display_cmd_type        pending_cmds[$];

   int                     error_count;
   int                     requests_sent;
   int                     writes_seen;
   int                     scrolls_seen;
   int                     clears_seen;
   int                     settings_used;

   // Idling controls: bursts are allowed while bursty is set, and never once
   // the closing stretch of the run has begun.
   bit                     bursty;
   bit                     quiet;

   text_console_cursor_engine dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command       (rsp_command),
      .rsp_screen_row    (rsp_screen_row),
      .rsp_screen_column (rsp_screen_column),
      .rsp_cell_word     (rsp_cell_word),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: the slowest correct run is far shorter than this.
   initial begin
      #3_000_000;
      $display("text_console_cursor_engine regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic display_cmd_type make_cmd(cmd_type command, int row, int column,
                                                logic [CELL_W-1:0] cell_word);
      display_cmd_type item;
      item.command   = command;
      item.row       = ROW_OUT_W'(row);
      item.column    = COL_OUT_W'(column);
      item.cell_word = cell_word;
      item.is_last   = 1'b0;
      return item;
   endfunction

   // Moves the cursor down one line. Returns 1 when the cursor already sits on
   // the bottom row, in which case the screen has to scroll instead.
   function automatic bit advance_row();
      if (cursor_row + 1 < ROWS) begin
         cursor_row++;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Works out the display commands one accepted request causes, updates the
   // cursor, and queues the commands in order with the final one flagged.
   function automatic void predict_console(logic operation, logic [CHAR_W-1:0] code);
      display_cmd_type caused[$];
      int              step;
      if (operation == OP_CLEAR) begin
         cursor_row    = 0;
         cursor_column = 0;
         caused.push_back(make_cmd(CMD_CLEAR, 0, 0, '0));
      end else if (code >= CHAR_FIRST_PRINT) begin
         // A write after the last column first wraps to the next line.
         if (cursor_column >= COLUMNS) begin
            if (advance_row())
               caused.push_back(make_cmd(CMD_SCROLL, 0, 0, '0));
            cursor_column = 0;
         end
         caused.push_back(make_cmd(CMD_WRITE, cursor_row, cursor_column,
                                   {text_bg, text_fg, code}));
         cursor_column++;
      end else if (code == CHAR_NEWLINE) begin
         if (advance_row())
            caused.push_back(make_cmd(CMD_SCROLL, 0, 0, '0));
         cursor_column = 0;
      end else if (code == CHAR_RETURN) begin
         cursor_column = 0;
      end else if (code == CHAR_TAB) begin
         step = tab_stop - cursor_column % tab_stop;
         cursor_column += step;
         if (cursor_column + 1 > COLUMNS) begin
            cursor_column = cursor_column % COLUMNS;
            if (advance_row())
               caused.push_back(make_cmd(CMD_SCROLL, 0, 0, '0));
         end
      end
      if (caused.size() > 0)
         caused[caused.size() - 1].is_last = 1'b1;
      foreach (caused[i])
         pending_cmds.push_back(caused[i]);
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   // Each accepted result is compared with the oldest outstanding command.
   always @(posedge clock) begin : result_check
      display_cmd_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_cmds.size() == 0) begin
            $error("unexpected result: command %0d row %0d column %0d cell %h",
                   rsp_command, rsp_screen_row, rsp_screen_column, rsp_cell_word);
            error_count++;
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_command !== want.command) begin
               $error("command: expected %0d, got %0d", want.command, rsp_command);
               error_count++;
            end
            if (rsp_screen_row !== want.row) begin
               $error("screen_row: expected %0d, got %0d", want.row, rsp_screen_row);
               error_count++;
            end
            if (rsp_screen_column !== want.column) begin
               $error("screen_column: expected %0d, got %0d", want.column,
                      rsp_screen_column);
               error_count++;
            end
            if (rsp_cell_word !== want.cell_word) begin
               $error("cell_word: expected %h, got %h", want.cell_word, rsp_cell_word);
               error_count++;
            end
            if (rsp_last !== want.is_last) begin
               $error("last: expected %0d, got %0d", want.is_last, rsp_last);
               error_count++;
            end
            case (want.command)
               CMD_WRITE:  writes_seen++;
               CMD_SCROLL: scrolls_seen++;
               default:    clears_seen++;
            endcase
         end
      end
   end

   // Output back-pressure: random bursts of stall.
   initial begin : output_stall
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0)
               rsp_stall <= 1'b0;
         end else if (bursty && !quiet && $urandom_range(0, 6) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(1, 5);
         end
      end
   end

   // ------------------------------------------------------------------
   // Shared driving tasks
   // ------------------------------------------------------------------

   // Presents one request and holds it until the block accepts it, then hands
   // it to the predictor. Returns just after a rising edge.
   task automatic send_request(logic operation, logic [CHAR_W-1:0] code);
      req_valid     <= 1'b1;
      req_operation <= operation;
      req_char_code <= code;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      predict_console(operation, code);
      requests_sent++;
      if (bursty && !quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Stops sending and waits for every outstanding result, then lets any
   // queued result-free requests drain from the back end.
   task automatic wait_until_idle(int settle);
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready is seen.
   task automatic csr_write(int index, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * index);
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // Mirror the write; out-of-range tab sizes and unlisted indexes are ignored.
      if (index == REG_FOREGROUND)
         text_fg = data[COLOR_W-1:0];
      else if (index == REG_BACKGROUND)
         text_bg = data[COLOR_W-1:0];
      else if (index == REG_TAB_SIZE && data[TAB_W-1:0] != 0 && data[TAB_W-1:0] < COLUMNS)
         tab_stop = data[TAB_W-1:0];
   endtask

   // Register read, compared with the predictor's copy. The read data is
   // sampled in the middle of the access cycle.
   task automatic csr_check(int index);
      logic [CSR_DATA_W-1:0] want;
      logic [CSR_DATA_W-1:0] got;
      if (index == REG_FOREGROUND)
         want = CSR_DATA_W'(text_fg);
      else if (index == REG_BACKGROUND)
         want = CSR_DATA_W'(text_bg);
      else
         want = CSR_DATA_W'(tab_stop);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'(4 * index);
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== want) begin
         $error("register %0d: expected %h, got %h", index, want, got);
         error_count++;
      end
   endtask

   task automatic apply_settings(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg, int tab);
      csr_write(REG_FOREGROUND, CSR_DATA_W'(fg));
      csr_write(REG_BACKGROUND, CSR_DATA_W'(bg));
      csr_write(REG_TAB_SIZE, CSR_DATA_W'(tab));
      settings_used++;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values, masking of wide writes, rejected tab sizes and a write to
   // an index past the register list.
   task automatic test_registers();
      csr_check(REG_FOREGROUND);
      csr_check(REG_BACKGROUND);
      csr_check(REG_TAB_SIZE);
      csr_write(REG_FOREGROUND, 32'hFFFF_FFF0);
      csr_write(REG_BACKGROUND, 32'h0000_001F);
      csr_write(REG_TAB_SIZE, 32'h0000_0000);
      csr_check(REG_TAB_SIZE);
      csr_write(REG_TAB_SIZE, CSR_DATA_W'(COLUMNS));
      csr_check(REG_TAB_SIZE);
      csr_write(REG_TAB_SIZE, 32'h0000_0185);
      csr_check(REG_TAB_SIZE);
      csr_write(REG_TAB_SIZE, 32'h0000_00FF);
      csr_write(REG_UNLISTED, 32'hA5A5_5A5A);
      csr_check(REG_FOREGROUND);
      csr_check(REG_BACKGROUND);
      csr_check(REG_TAB_SIZE);
      csr_write(REG_TAB_SIZE, CSR_DATA_W'(COLUMNS - 1));
      csr_check(REG_TAB_SIZE);
      csr_write(REG_TAB_SIZE, 32'h0000_0001);
      csr_check(REG_TAB_SIZE);
      csr_write(REG_TAB_SIZE, 32'h0000_0008);
      settings_used++;
   endtask

   // Both operations, the printable extremes and every kind of control code.
   task automatic test_characters();
      send_request(OP_CLEAR, CHAR_LAST_CODE);
      send_request(OP_CHARACTER, CHAR_FIRST_PRINT);
      send_request(OP_CHARACTER, CHAR_LAST_CODE);
      send_request(OP_CHARACTER, 8'h7F);
      send_request(OP_CHARACTER, 8'h80);
      send_request(OP_CHARACTER, CHAR_NUL);
      send_request(OP_CHARACTER, CHAR_UNIT_SEP);
      send_request(OP_CHARACTER, CHAR_ESCAPE);
      send_request(OP_CHARACTER, CHAR_BACKSPACE);
      send_request(OP_CHARACTER, CHAR_TAB);
      send_request(OP_CHARACTER, 8'h55);
      send_request(OP_CHARACTER, CHAR_RETURN);
      send_request(OP_CHARACTER, CHAR_NEWLINE);
      send_request(OP_CHARACTER, 8'hAA);
      send_request(OP_CLEAR, CHAR_NUL);
      wait_until_idle(SETTLE_CYCLES);
   endtask

   // Pending wrap after the last column, tabs from the last column and from
   // the wrap column, and the smallest tab size.
   task automatic test_wrap_and_tabs();
      apply_settings(4'hF, 4'h0, COLUMNS - 1);
      send_request(OP_CLEAR, 8'h3C);
      send_request(OP_CHARACTER, CHAR_TAB);
      send_request(OP_CHARACTER, 8'h41);
      send_request(OP_CHARACTER, CHAR_TAB);
      send_request(OP_CHARACTER, 8'h42);
      send_request(OP_CHARACTER, 8'h43);
      send_request(OP_CHARACTER, 8'h44);
      send_request(OP_CHARACTER, CHAR_RETURN);
      send_request(OP_CHARACTER, CHAR_TAB);
      send_request(OP_CHARACTER, CHAR_TAB);
      send_request(OP_CHARACTER, CHAR_NEWLINE);
      wait_until_idle(SETTLE_CYCLES);
      apply_settings(4'h9, 4'h6, 1);
      send_request(OP_CHARACTER, CHAR_TAB);
      send_request(OP_CHARACTER, CHAR_TAB);
      send_request(OP_CHARACTER, 8'h7E);
      wait_until_idle(SETTLE_CYCLES);
   endtask

   // The same cases on the bottom row, where each line advance scrolls.
   task automatic test_bottom_row();
      apply_settings(4'h3, 4'hC, COLUMNS - 1);
      send_request(OP_CLEAR, 8'h00);
      repeat (ROWS - 1) send_request(OP_CHARACTER, CHAR_NEWLINE);
      send_request(OP_CHARACTER, CHAR_NEWLINE);
      send_request(OP_CHARACTER, CHAR_TAB);
      send_request(OP_CHARACTER, 8'h5A);
      send_request(OP_CHARACTER, 8'h5A);
      send_request(OP_CHARACTER, CHAR_TAB);
      send_request(OP_CHARACTER, CHAR_TAB);
      send_request(OP_CHARACTER, 8'h61);
      send_request(OP_CHARACTER, 8'h62);
      send_request(OP_CHARACTER, CHAR_TAB);
      wait_until_idle(SETTLE_CYCLES);
   endtask

   task automatic send_random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 1)
         send_request(OP_CLEAR, CHAR_W'($urandom));
      else if (pick < 66)
         send_request(OP_CHARACTER,
                      CHAR_W'($urandom_range(CHAR_FIRST_PRINT, CHAR_LAST_CODE)));
      else if (pick < 84)
         send_request(OP_CHARACTER, CHAR_NEWLINE);
      else if (pick < 92)
         send_request(OP_CHARACTER, CHAR_TAB);
      else if (pick < 96)
         send_request(OP_CHARACTER, CHAR_RETURN);
      else
         send_request(OP_CHARACTER, CHAR_W'($urandom_range(0, CHAR_FIRST_PRINT - 1)));
   endtask

   // Random text in six phases under different colour and tab settings. Each
   // phase mixes stretches with and without idling; the last has none.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         wait_until_idle(SETTLE_CYCLES);
         case (phase)
            0: apply_settings(4'hF, 4'h0, 8);
            1: apply_settings(4'h0, 4'hF, 1);
            2: apply_settings(4'hF, 4'hF, COLUMNS - 1);
            3: apply_settings(COLOR_W'($urandom), COLOR_W'($urandom),
                              $urandom_range(1, COLUMNS - 1));
            4: apply_settings(4'h0, 4'h0, 2);
            default: apply_settings(COLOR_W'($urandom), COLOR_W'($urandom),
                                    $urandom_range(1, 16));
         endcase
         quiet = (phase == 5);
         for (int i = 0; i < 125; i++) begin
            bursty = ((i / 40) % 2) == 0;
            // Once per phase the sender holds off until the output has caught up.
            if (i == 60)
               wait_until_idle(0);
            send_random_request();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------

   initial begin : run_tests
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_CHARACTER;
      req_char_code = '0;
      rsp_stall     = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      text_fg       = FOREGROUND_RESET;
      text_bg       = BACKGROUND_RESET;
      tab_stop      = TAB_SIZE_RESET;
      cursor_row    = 0;
      cursor_column = 0;
      error_count   = 0;
      requests_sent = 0;
      writes_seen   = 0;
      scrolls_seen  = 0;
      clears_seen   = 0;
      settings_used = 0;
      bursty        = 1'b1;
      quiet         = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_registers();
      test_characters();
      test_wrap_and_tabs();
      test_bottom_row();
      test_random_traffic();
      wait_until_idle(SETTLE_CYCLES);

      $display("Covered %0d requests under %0d register settings.", requests_sent,
               settings_used);
      $display("Checked %0d cell writes, %0d scrolls and %0d clears.", writes_seen,
               scrolls_seen, clears_seen);
      if (error_count == 0)
         $display("text_console_cursor_engine regression: pass");
      else
         $display("text_console_cursor_engine regression: fail");
      $finish;
   end

endmodule

@@ text_console_cursor_engine.f @@
rtl/tcce_pkg.sv
rtl/tcce_csr.sv
rtl/tcce_front.sv
rtl/tcce_queue.sv
rtl/tcce_back.sv
rtl/text_console_cursor_engine.sv
tb/testbench.sv
